// ===== sv/tlsrs_pkg.sv =====
// ----------------------------------------------------------------------------
// TLS record splitter package
// Shared widths, constants and payload types for the record splitter.
// ----------------------------------------------------------------------------
package tlsrs_pkg;

    localparam int LENGTH_BITS = 17;
    localparam int HDR_BYTES   = 5;
    localparam int BURST_MAX   = 6;
    localparam int CNT_W       = $clog2(BURST_MAX + 1);

    localparam logic [7:0] TYPE_LOW  = 8'h14;
    localparam logic [7:0] TYPE_HIGH = 8'h18;
    localparam logic [7:0] MAJOR_VER = 8'h03;

    typedef struct packed {
        logic [7:0]             in_byte;
        logic [LENGTH_BITS-1:0] buffer_length;
        logic                   in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       segment_end;
        logic       out_last;
        logic       split_applied;
    } out_item_t;

    // Output bytes caused by one input byte, entry 0 goes out first
    typedef struct packed {
        out_item_t [BURST_MAX-1:0] item;
        logic [CNT_W-1:0]          count;
    } burst_t;

endpackage

// ===== sv/tlsrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// TLS record splitter control
// Tracks the buffer position and phase, holds the record header and builds
// the burst of output bytes for each accepted input byte.
// ----------------------------------------------------------------------------
module tlsrs_ctrl
    import tlsrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_item_t    rx_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output burst_t      burst,
    output logic        burst_push
);

    typedef enum logic [1:0] {
        PH_COLLECT,
        PH_PAYLOAD,
        PH_PASS
    } phase_t;

    localparam logic [LENGTH_BITS-1:0] HDR_LAST = LENGTH_BITS'(HDR_BYTES - 1);
    localparam logic [LENGTH_BITS-1:0] HDR_LEN  = LENGTH_BITS'(HDR_BYTES);

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [15:0]            rec_len_reg, rec_len_next;
    logic [15:0]            first_len_reg, first_len_next;
    logic                   splitting_reg, splitting_next;
    logic [15:0]            split_pos_reg;
    logic [7:0]             held_reg [HDR_BYTES];

    logic [2:0]             hdr_idx;
    logic [15:0]            rl;
    logic [15:0]            fp_sel;
    logic [15:0]            second_len;
    logic [LENGTH_BITS:0]   rec_end;
    logic                   qualify;
    logic [LENGTH_BITS-1:0] pos_adv;
    logic                   at_first_end;
    logic                   at_rec_end;
    logic [7:0]             b;
    logic                   last;

    function automatic out_item_t mk(logic [7:0] d, logic seg, logic lst, logic spl);
        out_item_t r;
        r.out_byte      = d;
        r.segment_end   = seg;
        r.out_last      = lst;
        r.split_applied = spl;
        return r;
    endfunction

    assign b          = rx_data.in_byte;
    assign last       = rx_data.in_last;
    assign hdr_idx    = pos_reg[2:0];
    assign rl         = {held_reg[3], b};
    assign rec_end    = (LENGTH_BITS+1)'(HDR_BYTES) + (LENGTH_BITS+1)'(rl);
    assign qualify    = (held_reg[0] >= TYPE_LOW) && (held_reg[0] <= TYPE_HIGH)
                        && (held_reg[1] == MAJOR_VER) && (rl >= 16'd2)
                        && (rec_end <= {1'b0, rx_data.buffer_length}) && !last;
    assign fp_sel     = (split_pos_reg == 16'd0 || split_pos_reg >= rl) ? 16'd1
                                                                      : split_pos_reg;
    assign second_len = rec_len_reg - first_len_reg;
    assign pos_adv    = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
    assign at_first_end = (pos_reg == LENGTH_BITS'(first_len_reg) + HDR_LAST);
    assign at_rec_end   = (pos_reg == LENGTH_BITS'(rec_len_reg) + HDR_LAST);

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        rec_len_next   = rec_len_reg;
        first_len_next = first_len_reg;
        splitting_next = splitting_reg;
        burst          = '0;

        unique case (phase_reg)
            PH_COLLECT:
            begin
                if (hdr_idx < 3'(HDR_BYTES - 1))
                begin
                    if (last)
                    begin
                        // short buffer: flush the held bytes as they came
                        for (int i = 0; i < HDR_BYTES - 1; i++)
                        begin
                            burst.item[i] = mk((3'(i) < hdr_idx) ? held_reg[i] : b,
                                               3'(i) == hdr_idx, 3'(i) == hdr_idx, 1'b0);
                        end
                        burst.count = CNT_W'(hdr_idx) + 1'b1;
                        pos_next    = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                else if (qualify)
                begin
                    // rewrite the header with the first record's length
                    burst.item[0] = mk(held_reg[0], 1'b0, 1'b0, 1'b1);
                    burst.item[1] = mk(held_reg[1], 1'b0, 1'b0, 1'b1);
                    burst.item[2] = mk(held_reg[2], 1'b0, 1'b0, 1'b1);
                    burst.item[3] = mk(fp_sel[15:8], 1'b0, 1'b0, 1'b1);
                    burst.item[4] = mk(fp_sel[7:0], 1'b0, 1'b0, 1'b1);
                    burst.count    = CNT_W'(HDR_BYTES);
                    rec_len_next   = rl;
                    first_len_next = fp_sel;
                    splitting_next = 1'b1;
                    phase_next     = PH_PAYLOAD;
                    pos_next       = HDR_LEN;
                end
                else
                begin
                    burst.item[0] = mk(held_reg[0], 1'b0, 1'b0, 1'b0);
                    burst.item[1] = mk(held_reg[1], 1'b0, 1'b0, 1'b0);
                    burst.item[2] = mk(held_reg[2], 1'b0, 1'b0, 1'b0);
                    burst.item[3] = mk(held_reg[3], 1'b0, 1'b0, 1'b0);
                    burst.item[4] = mk(b, last, last, 1'b0);
                    burst.count   = CNT_W'(HDR_BYTES);
                    if (last)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_PASS;
                        pos_next   = HDR_LEN;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                burst.count = CNT_W'(1);
                if (last)
                begin
                    burst.item[0] = mk(b, 1'b1, 1'b1, 1'b1);
                end
                else if (at_first_end)
                begin
                    // close record one and open record two
                    burst.item[0] = mk(b, 1'b1, 1'b0, 1'b1);
                    burst.item[1] = mk(held_reg[0], 1'b0, 1'b0, 1'b1);
                    burst.item[2] = mk(held_reg[1], 1'b0, 1'b0, 1'b1);
                    burst.item[3] = mk(held_reg[2], 1'b0, 1'b0, 1'b1);
                    burst.item[4] = mk(second_len[15:8], 1'b0, 1'b0, 1'b1);
                    burst.item[5] = mk(second_len[7:0], 1'b0, 1'b0, 1'b1);
                    burst.count   = CNT_W'(BURST_MAX);
                    pos_next      = pos_adv;
                end
                else if (at_rec_end)
                begin
                    burst.item[0] = mk(b, 1'b1, 1'b0, 1'b1);
                    phase_next    = PH_PASS;
                    pos_next      = pos_adv;
                end
                else
                begin
                    burst.item[0] = mk(b, 1'b0, 1'b0, 1'b1);
                    pos_next      = pos_adv;
                end
            end
            PH_PASS:
            begin
                burst.item[0] = mk(b, last, last, splitting_reg);
                burst.count   = CNT_W'(1);
                pos_next      = pos_adv;
            end
            default:
            begin
                phase_next = PH_COLLECT;
            end
        endcase

        // buffer end drops all per-buffer state
        if (last)
        begin
            phase_next     = PH_COLLECT;
            pos_next       = '0;
            rec_len_next   = '0;
            first_len_next = '0;
            splitting_next = 1'b0;
        end
    end

    assign burst_push = accept && (burst.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_COLLECT;
            pos_reg       <= '0;
            rec_len_reg   <= '0;
            first_len_reg <= '0;
            splitting_reg <= 1'b0;
            split_pos_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                rec_len_reg   <= rec_len_next;
                first_len_reg <= first_len_next;
                splitting_reg <= splitting_next;
            end
            if (cfg_we)
            begin
                split_pos_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_COLLECT && hdr_idx < 3'(HDR_BYTES))
        begin
            held_reg[hdr_idx] <= b;
        end
    end

    a_payload_lengths: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> splitting_reg && first_len_reg != 16'd0
                                    && first_len_reg < rec_len_reg)
        else $error("payload phase with inconsistent record lengths");

    a_collect_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_COLLECT |-> pos_reg < HDR_LEN && !splitting_reg)
        else $error("header collection beyond header bytes");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> phase_reg == PH_COLLECT && pos_reg == '0)
        else $error("buffer end did not restart header collection");

endmodule

// ===== sv/tlsrs_emit.sv =====
// ----------------------------------------------------------------------------
// TLS record splitter output stage
// Holds one burst of output bytes and drains it, one byte per cycle while tx
// is not stalled, into the output register.
// ----------------------------------------------------------------------------
module tlsrs_emit
    import tlsrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  burst_t    burst,
    input  logic      burst_push,
    output logic      burst_ready,
    output logic      tx_valid,
    input  logic      tx_stall,
    output out_item_t tx_data
);

    out_item_t [BURST_MAX-1:0] items_reg, items_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;
    logic                      out_load;
    logic                      pop;

    assign out_load    = !out_valid_reg || !tx_stall;
    assign pop         = (count_reg != '0) && out_load;
    assign burst_ready = (count_reg == '0) || (count_reg == CNT_W'(1) && out_load);

    always_comb
    begin
        items_next = items_reg;
        count_next = count_reg;
        if (burst_push)
        begin
            items_next = burst.item;
            count_next = burst.count;
        end
        else if (pop)
        begin
            // advance the burst by one byte
            for (int i = 0; i < BURST_MAX - 1; i++)
            begin
                items_next[i] = items_reg[i + 1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= (count_reg != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
        if (pop)
        begin
            out_data_reg <= items_reg[0];
        end
    end

    assign tx_valid = out_valid_reg;
    assign tx_data  = out_data_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BURST_MAX))
        else $error("burst count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg > CNT_W'(1) |-> !burst_push)
        else $error("new burst would overwrite pending bytes");

    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> tx_valid)
        else $error("popped byte not presented");

endmodule

// ===== sv/tls_record_splitter.sv =====
// ----------------------------------------------------------------------------
// TLS record splitter
// Splits a qualifying TLS record at the head of a write buffer into two.
// ----------------------------------------------------------------------------
// Bytes of a write buffer enter on rx, one per cycle when rx is not stalled,
// pass the burst register and the output register, and leave one per cycle
// on tx when tx is not stalled. The first four header bytes are held without
// output; the fifth releases the rewritten (or unchanged) header as five
// bytes, which stalls rx while the burst drains. When a record is split the
// last byte of record one is followed by the five bytes of the second header,
// which stalls rx again while that burst drains. Throughput is set by the
// burst register, which drains one byte per cycle into the output register
// when tx is not stalled and takes a new input byte once it is empty or its
// last byte is moving out. The split point, written through cfg_we/cfg_wdata,
// is to be written by the user only while the block is idle; the block itself does not enforce this.
module tls_record_splitter
    import tlsrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  in_item_t    rx_data,
    output logic        tx_valid,
    input  logic        tx_stall,
    output out_item_t   tx_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    burst_t burst;
    logic   burst_push;
    logic   burst_ready;
    logic   accept;

    assign rx_stall = !burst_ready;
    assign accept   = rx_valid && burst_ready;

    tlsrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_data    (rx_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .burst      (burst),
        .burst_push (burst_push)
    );

    tlsrs_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst       (burst),
        .burst_push  (burst_push),
        .burst_ready (burst_ready),
        .tx_valid    (tx_valid),
        .tx_stall    (tx_stall),
        .tx_data     (tx_data)
    );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// TLS record splitter testbench
// Feeds write buffers byte by byte, both well-formed records and noise, and
// checks every output byte against an in-bench model of the record rewrite.
// ----------------------------------------------------------------------------
module testbench;
    import tlsrs_pkg::*;

    typedef enum logic [1:0] {PH_COLLECT, PH_PAYLOAD, PH_PASS} split_phase_t;

    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 110;
    localparam int ERR_PRINTS   = 100;
    localparam logic [7:0] TYPE_APPDATA = 8'h17;
    localparam logic [LENGTH_BITS-1:0] BLEN_MAX = '1;

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_stall;
    in_item_t    rx_data;
    logic        tx_valid;
    logic        tx_stall;
    out_item_t   tx_data;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    tls_record_splitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_data   (rx_data),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_data   (tx_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Model state of the splitter
    logic [15:0]            mdl_split_pos;
    logic [LENGTH_BITS-1:0] mdl_pos;
    logic [7:0]             mdl_hdr [0:HDR_BYTES-1];
    split_phase_t           mdl_phase;
    logic [15:0]            mdl_rec_len;
    logic [15:0]            mdl_first_len;
    logic                   mdl_splitting;

    out_item_t  expected_bytes [$];
    logic [7:0] buf_bytes [$];
    int         err_count;
    int         idle_cycles;
    int         sent_bytes;
    bit         quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_buffer_state();
        mdl_pos       = '0;
        for (int i = 0; i < HDR_BYTES; i++)
            mdl_hdr[i] = '0;
        mdl_phase     = PH_COLLECT;
        mdl_rec_len   = '0;
        mdl_first_len = '0;
        mdl_splitting = 1'b0;
    endfunction

    function automatic void push_out(logic [7:0] b, logic seg, logic lst, logic spl);
        out_item_t o;
        o.out_byte      = b;
        o.segment_end   = seg;
        o.out_last      = lst;
        o.split_applied = spl;
        expected_bytes.push_back(o);
    endfunction

    function automatic void push_header(logic [15:0] len);
        push_out(mdl_hdr[0], 1'b0, 1'b0, 1'b1);
        push_out(mdl_hdr[1], 1'b0, 1'b0, 1'b1);
        push_out(mdl_hdr[2], 1'b0, 1'b0, 1'b1);
        push_out(len[15:8], 1'b0, 1'b0, 1'b1);
        push_out(len[7:0], 1'b0, 1'b0, 1'b1);
    endfunction

    function automatic void advance_pos();
        if (mdl_pos != BLEN_MAX)
            mdl_pos = mdl_pos + 1'b1;
    endfunction

    // Work out the output bytes that one accepted input byte causes
    function automatic void rewrite_byte(in_item_t it);
        int          hp;
        int          p;
        logic [15:0] rl;
        logic [15:0] fp;
        logic        ok;
        case (mdl_phase)
            PH_COLLECT:
            begin
                hp = (mdl_pos < HDR_BYTES) ? int'(mdl_pos) : HDR_BYTES - 1;
                mdl_hdr[hp] = it.in_byte;
                if (hp < HDR_BYTES - 1)
                begin
                    if (it.in_last)
                    begin
                        for (int i = 0; i <= hp; i++)
                            push_out(mdl_hdr[i], i == hp, i == hp, 1'b0);
                        clear_buffer_state();
                    end
                    else
                        mdl_pos = LENGTH_BITS'(hp + 1);
                end
                else
                begin
                    rl = {mdl_hdr[3], mdl_hdr[4]};
                    ok = mdl_hdr[0] >= TYPE_LOW && mdl_hdr[0] <= TYPE_HIGH &&
                         mdl_hdr[1] == MAJOR_VER && rl >= 16'd2 &&
                         (HDR_BYTES + int'(rl)) <= int'(it.buffer_length) && !it.in_last;
                    if (ok)
                    begin
                        fp = mdl_split_pos;
                        if (fp == 16'd0 || fp >= rl)
                            fp = 16'd1;
                        mdl_rec_len   = rl;
                        mdl_first_len = fp;
                        mdl_splitting = 1'b1;
                        push_header(fp);
                        mdl_phase = PH_PAYLOAD;
                        mdl_pos   = LENGTH_BITS'(HDR_BYTES);
                    end
                    else
                    begin
                        for (int i = 0; i < HDR_BYTES; i++)
                            push_out(mdl_hdr[i], (i == HDR_BYTES - 1) && it.in_last,
                                     (i == HDR_BYTES - 1) && it.in_last, 1'b0);
                        if (it.in_last)
                            clear_buffer_state();
                        else
                        begin
                            mdl_phase = PH_PASS;
                            mdl_pos   = LENGTH_BITS'(HDR_BYTES);
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                p = int'(mdl_pos) - HDR_BYTES;
                if (it.in_last)
                begin
                    push_out(it.in_byte, 1'b1, 1'b1, 1'b1);
                    clear_buffer_state();
                end
                else
                begin
                    if (p + 1 == int'(mdl_first_len))
                    begin
                        // end of record one: insert the second header
                        push_out(it.in_byte, 1'b1, 1'b0, 1'b1);
                        push_header(mdl_rec_len - mdl_first_len);
                    end
                    else if (p + 1 == int'(mdl_rec_len))
                    begin
                        push_out(it.in_byte, 1'b1, 1'b0, 1'b1);
                        mdl_phase = PH_PASS;
                    end
                    else
                        push_out(it.in_byte, 1'b0, 1'b0, 1'b1);
                    advance_pos();
                end
            end
            default:
            begin
                push_out(it.in_byte, it.in_last, it.in_last, mdl_splitting);
                if (it.in_last)
                    clear_buffer_state();
                else
                    advance_pos();
            end
        endcase
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            if (err_count < ERR_PRINTS)
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_val, act_val);
            err_count++;
        end
    endfunction

    // Monitor: predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        out_item_t exp_item;
        if (rst_n)
        begin
            if (cfg_we)
                mdl_split_pos = cfg_wdata;
            if (rx_valid && !rx_stall)
                rewrite_byte(rx_data);
            if (tx_valid && !tx_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    if (err_count < ERR_PRINTS)
                        $display("%0t: unexpected output, expected none actual %0h",
                                 $time, tx_data);
                    err_count++;
                end
                else
                begin
                    exp_item = expected_bytes.pop_front();
                    check_field("out_byte", int'(exp_item.out_byte),
                                int'(tx_data.out_byte));
                    check_field("segment_end", int'(exp_item.segment_end),
                                int'(tx_data.segment_end));
                    check_field("out_last", int'(exp_item.out_last),
                                int'(tx_data.out_last));
                    check_field("split_applied", int'(exp_item.split_applied),
                                int'(tx_data.split_applied));
                end
            end
            if ((rx_valid && !rx_stall) || (tx_valid && !tx_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("tls_record_splitter test failed");
                $finish;
            end
        end
    end

    // Receiver stall: runs of random length, mostly short
    initial
    begin
        int run;
        run = 0;
        forever
        begin
            @(negedge clk);
            if (run > 0)
                run--;
            else if (quiet || tx_stall)
            begin
                tx_stall <= 1'b0;
                run = $urandom_range(0, 10);
            end
            else
            begin
                tx_stall <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            rx_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_valid <= 1'b1;
        rx_data  <= it;
        do
            @(posedge clk);
        while (rx_stall);
        sent_bytes++;
    endtask

    task automatic send_buffer(logic [LENGTH_BITS-1:0] blen);
        in_item_t it;
        for (int i = 0; i < buf_bytes.size(); i++)
        begin
            it.in_byte       = buf_bytes[i];
            it.buffer_length = blen;
            it.in_last       = (i == buf_bytes.size() - 1);
            send_item(it);
        end
    endtask

    // Header, body bytes of payload, then tail bytes of trailing data
    function automatic void build_record(logic [7:0] rtype, logic [7:0] major,
                                         logic [15:0] rl, int body, int tail);
        buf_bytes.delete();
        buf_bytes.push_back(rtype);
        buf_bytes.push_back(major);
        buf_bytes.push_back(8'($urandom_range(0, 255)));
        buf_bytes.push_back(rl[15:8]);
        buf_bytes.push_back(rl[7:0]);
        repeat (body + tail) buf_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Drop valid and let the block drain before touching the register
    task automatic wait_idle();
        @(negedge clk);
        rx_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_split(logic [15:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic test_short_buffers();
        for (int n = 1; n < HDR_BYTES; n++)
        begin
            build_record(TYPE_APPDATA, MAJOR_VER, 16'd10, 0, 0);
            while (buf_bytes.size() > n)
                void'(buf_bytes.pop_back());
            send_buffer(BLEN_MAX);
        end
        // header only, even though it would qualify
        build_record(TYPE_APPDATA, MAJOR_VER, 16'd3, 0, 0);
        send_buffer(17'd100);
    endtask

    task automatic test_header_checks();
        set_split(16'd2);
        build_record(TYPE_LOW - 8'd1, MAJOR_VER, 16'd3, 3, 0);
        send_buffer(17'd8);
        build_record(TYPE_LOW, MAJOR_VER, 16'd3, 3, 0);
        send_buffer(17'd8);
        build_record(TYPE_HIGH, MAJOR_VER, 16'd3, 3, 0);
        send_buffer(17'd8);
        build_record(TYPE_HIGH + 8'd1, MAJOR_VER, 16'd3, 3, 0);
        send_buffer(17'd8);
        build_record(TYPE_APPDATA, MAJOR_VER - 8'd1, 16'd3, 3, 0);
        send_buffer(17'd8);
        build_record(TYPE_APPDATA, MAJOR_VER, 16'd1, 1, 0);
        send_buffer(17'd6);
        build_record(TYPE_APPDATA, MAJOR_VER, 16'd0, 0, 2);
        send_buffer(17'd7);
        // record one byte longer than the buffer claims
        build_record(TYPE_APPDATA, MAJOR_VER, 16'd3, 3, 0);
        send_buffer(17'd7);
    endtask

    task automatic test_split_settings();
        logic [15:0] settings [5];
        settings = '{16'd0, 16'd1, 16'd3, 16'd4, 16'hFFFF};
        foreach (settings[i])
        begin
            set_split(settings[i]);
            build_record(TYPE_APPDATA, MAJOR_VER, 16'd4, 4, 2);
            send_buffer(17'd11);
        end
    endtask

    task automatic test_buffer_ends();
        set_split(16'd2);
        // end on the last byte of record one
        build_record(TYPE_APPDATA, MAJOR_VER, 16'd6, 2, 0);
        send_buffer(17'd11);
        // truncated inside record two
        build_record(TYPE_APPDATA, MAJOR_VER, 16'd6, 4, 0);
        send_buffer(17'd11);
        // end exactly at the record end, buffer length far too big
        build_record(TYPE_APPDATA, MAJOR_VER, 16'd6, 6, 0);
        send_buffer(BLEN_MAX);
        // largest record length, cut short after a few bytes
        build_record(TYPE_HIGH, MAJOR_VER, 16'hFFFF, 3, 0);
        send_buffer(BLEN_MAX);
    endtask

    task automatic test_random_traffic();
        int          start;
        int          nbuf;
        int          r;
        int          rl;
        int          body;
        int          tail;
        int          n;
        logic [LENGTH_BITS-1:0] blen;
        start = sent_bytes;
        nbuf  = 0;
        while (sent_bytes - start < RANDOM_BYTES)
        begin
            nbuf++;
            if (nbuf % 6 == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       set_split(16'd0);
                    1:       set_split(16'hFFFF);
                    2:       set_split(16'($urandom_range(1, 24)));
                    3:       set_split(16'($urandom_range(0, 65535)));
                    default: set_split(16'd1);
                endcase
            end
            quiet = (nbuf % 10) >= 7;
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                rl   = $urandom_range(2, 24);
                body = ($urandom_range(0, 4) != 0) ? rl : $urandom_range(0, rl - 1);
                tail = (body == rl) ? $urandom_range(0, 6) : 0;
                build_record(8'($urandom_range(TYPE_LOW, TYPE_HIGH)), MAJOR_VER, 16'(rl),
                             body, tail);
                blen = $urandom_range(0, 1) ? LENGTH_BITS'(HDR_BYTES + rl + tail)
                                            : LENGTH_BITS'($urandom_range(HDR_BYTES + rl,
                                                                          BLEN_MAX));
                send_buffer(blen);
            end
            else if (r < 80)
            begin
                rl = $urandom_range(25, 65535);
                build_record(8'($urandom_range(TYPE_LOW, TYPE_HIGH)), MAJOR_VER, 16'(rl),
                             $urandom_range(1, 6), 0);
                send_buffer(LENGTH_BITS'($urandom_range(HDR_BYTES + rl, BLEN_MAX)));
            end
            else
            begin
                build_record($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(8'h13, 8'h19)),
                             $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : MAJOR_VER,
                             16'($urandom_range(0, 30)), $urandom_range(0, 30), 0);
                if (r >= 95)
                begin
                    n = $urandom_range(1, HDR_BYTES - 1);
                    while (buf_bytes.size() > n)
                        void'(buf_bytes.pop_back());
                end
                send_buffer(LENGTH_BITS'($urandom_range(1, BLEN_MAX)));
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        rx_valid   = 1'b0;
        rx_data    = '0;
        tx_stall   = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        err_count  = 0;
        idle_cycles = 0;
        sent_bytes = 0;
        quiet      = 1'b0;
        mdl_split_pos = '0;
        clear_buffer_state();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_short_buffers();
        test_header_checks();
        test_split_settings();
        test_buffer_ends();
        test_random_traffic();

        wait_idle();
        if (expected_bytes.size() != 0)
        begin
            $display("%0t: missing output, expected %0d more actual 0",
                     $time, expected_bytes.size());
            err_count++;
        end
        if (err_count == 0)
            $display("tls_record_splitter test passed");
        else
            $display("tls_record_splitter test failed");
        $finish;
    end

endmodule
